### src/wgm_pkg.sv
// Package for the wildcard glob matcher: sizes, pattern byte codes,
// register indexes and the structs passed along the cell chain.
// No dependencies.
`default_nettype none

package wgm_pkg;

   localparam int MAX_PATTERN    = 32;
   localparam int LEN_W          = $clog2(MAX_PATTERN + 1);
   localparam int CHAR_W         = 8;
   localparam int WORD_W         = 64;
   localparam int PAT_WORDS      = 4;
   localparam int BYTES_PER_WORD = WORD_W / CHAR_W;
   localparam int PAT_BYTES      = PAT_WORDS * BYTES_PER_WORD;
   localparam int CSR_IDX_W      = 3;

   localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_3 = 3'd4;

   // Per-beat control broadcast to every cell
   typedef struct packed {
      logic              load;
      logic              start;
      logic              consume;
      logic [CHAR_W-1:0] text_char;
   } wgm_ctl_type;

   // Handed from cell j-1 to cell j
   typedef struct packed {
      logic reload;    // reload row bit j-1
      logic row;       // old row bit j-1 (after any reload)
      logic next;      // new row bit j-1
   } wgm_link_type;

endpackage

`default_nettype wire

### src/wgm_cell.sv
// One pattern position of the match row: holds row bit j and updates it
// from its left neighbor's link. Depends on wgm_pkg.
`default_nettype none

module wgm_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  wgm_pkg::wgm_ctl_type           ctl,
   input  logic [wgm_pkg::CHAR_W-1:0]     pat_char,
   input  logic                           active,
   input  wgm_pkg::wgm_link_type          link_in,
   output wgm_pkg::wgm_link_type          link_out,
   output logic                           bit_next
);
   import wgm_pkg::*;

   logic row_ff;
   logic row_in;
   logic is_star;
   logic hit;
   logic reload_bit;
   logic old_self;
   logic new_bit;

   always_comb begin
      is_star    = (pat_char == STAR_BYTE);
      hit        = (pat_char == ANY_BYTE) || (pat_char == ctl.text_char);
      reload_bit = active & is_star & link_in.reload;
      old_self   = ctl.start ? reload_bit : row_ff;
      if (!active) begin
         new_bit = 1'b0;
      end else if (is_star) begin
         new_bit = link_in.next | old_self | link_in.row;
      end else if (hit) begin
         new_bit = link_in.row;
      end else begin
         new_bit = 1'b0;
      end
      row_in   = ctl.consume ? new_bit : old_self;
      bit_next = row_in;
      link_out = '{reload: reload_bit, row: old_self, next: new_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 1'b0;
      end else if (ctl.load) begin
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### src/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: config registers, row bit 0,
// the chain of wgm_cell instances and the registered result beat.
// Depends on wgm_pkg and wgm_cell.
//
//   port group | direction | contents
//   req_*      | in        | text_char, start_of_text, empty_text; valid/stall
//   rsp_*      | out       | match; valid/stall
//   csr_*      | in        | write, index, data (64 bits)
//
// One req beat per cycle while req_stall is low; its rsp beat is valid the following cycle.
// The row update is one combinational pass down the cell chain (reload
// chain, then star OR chain), so the chain length sets the clock period.
// req_stall is high only while a result sits in the output register and
// rsp_stall holds it. Synchronous reset clears the row, config registers and valid.
`default_nettype none

module wildcard_glob_matcher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wgm_pkg::CHAR_W-1:0]        req_text_char,
   input  logic                              req_start_of_text,
   input  logic                              req_empty_text,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_match,
   input  logic                              csr_write,
   input  logic [wgm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wgm_pkg::WORD_W-1:0]        csr_data
);
   import wgm_pkg::*;

   logic [LEN_W-1:0]                len_ff;
   logic [PAT_WORDS-1:0][WORD_W-1:0] word_ff;
   logic [LEN_W-1:0]                eff_len;
   logic                            bit0_ff;
   logic                            bit0_in;
   logic                            rsp_valid_ff;
   logic                            rsp_match_ff;
   logic                            match_in;
   logic                            accept;
   wgm_ctl_type                     ctl;
   wgm_link_type                    link [0:MAX_PATTERN];
   logic [MAX_PATTERN:0]            row_next;
   logic [PAT_BYTES*CHAR_W-1:0]     pat_bits;

   assign pat_bits  = word_ff;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

   always_comb begin
      if (len_ff > LEN_W'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = len_ff;
      end
      ctl = '{load: accept, start: req_start_of_text, consume: ~req_empty_text,
              text_char: req_text_char};
      if (ctl.consume) begin
         bit0_in = 1'b0;
      end else if (ctl.start) begin
         bit0_in = 1'b1;
      end else begin
         bit0_in = bit0_ff;
      end
   end

   assign link[0]     = '{reload: 1'b1, row: ctl.start | bit0_ff, next: 1'b0};
   assign row_next[0] = bit0_in;

   for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
      localparam logic [LEN_W-1:0] POS = LEN_W'(j);
      logic [CHAR_W-1:0] pat_char;
      logic              active;
      if (j - 1 < PAT_BYTES) begin : g_byte
         assign pat_char = pat_bits[(j-1)*CHAR_W +: CHAR_W];
      end else begin : g_zero
         assign pat_char = '0;
      end
      assign active = (POS <= eff_len);
      wgm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .pat_char (pat_char),
         .active   (active),
         .link_in  (link[j-1]),
         .link_out (link[j]),
         .bit_next (row_next[j])
      );
   end

   always_comb begin
      match_in = 1'b0;
      for (int j = 0; j <= MAX_PATTERN; j++) begin
         if (eff_len == LEN_W'(j)) begin
            match_in = row_next[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         word_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: len_ff     <= csr_data[LEN_W-1:0];
            CSR_PATTERN_WORD_0: word_ff[0] <= csr_data;
            CSR_PATTERN_WORD_1: word_ff[1] <= csr_data;
            CSR_PATTERN_WORD_2: word_ff[2] <= csr_data;
            CSR_PATTERN_WORD_3: word_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit0_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            bit0_ff      <= bit0_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

### src/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Imports wgm_pkg; its ports are all single-bit.
`default_nettype none

module wgm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_match
);
   import wgm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match))
      else $error("held rsp beat changed");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted req beat gave no rsp beat");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with output free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

`default_nettype wire
